// ----- rtl/pol_pkg.sv -----
package pol_pkg;

    // Cell index width: CAPACITY tops out at 256, so cell indexes and
    // list positions fit in nine bits.
    localparam int POS_W = 9;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_TAKE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic        [4:0]  position;
        logic signed [31:0] entry_key;
        logic signed [31:0] entry_value;
    } pol_in_t;

    typedef struct packed {
        status_t            status;
        logic               removed_valid;
        logic signed [31:0] removed_key;
        logic signed [31:0] removed_value;
        logic        [4:0]  count;
    } pol_out_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] value;
    } entry_t;

    // Broadcast to every cell in the row.
    typedef struct packed {
        logic             ins;   // open a gap at pos, shift tailward
        logic             rem;   // close the gap at pos, shift headward
        logic [POS_W-1:0] pos;
        entry_t           entry; // new entry for an insert
    } cell_cmd_t;

endpackage

// ----- rtl/positional_ordered_list_unit.sv -----
// Positional ordered list: holds up to CAPACITY (key, value) entries in
// position order, head at position 0, in a row of cells that each keep one
// entry. Each input beat requests append at the tail, insert at a position,
// remove at a position or take from the head; every input beat yields
// exactly one result beat with a status, the removed entry (zeros when none)
// and the count after the operation. A request is decided and applied in the
// cycle it is accepted: all cells shift towards the tail (insert) or the head
// (remove) together, so the unit sustains one beat per cycle unless m_ready
// holds back a full result register, and the result is registered. The removed entry is
// gathered from the addressed cell through an OR tree across the row, which
// sets the clock-to-clock path together with the position compares in each
// cell. The result register decouples the two sides: a new beat is taken
// while a finished result is being handed over. There is no clearing pass;
// a cell is only ever read below the fill count. The count field is five
// bits wide and wraps for a CAPACITY above 31.
module positional_ordered_list_unit
    import pol_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pol_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pol_out_t m_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // Control state.
    logic [CW-1:0] fill_count_reg;
    logic [CW-1:0] fill_count_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    pol_out_t      out_reg;
    pol_out_t      out_next;

    logic          accept;
    status_t       status;
    logic          do_ins;
    logic          do_rem;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] fill_x;
    logic          empty;
    logic          full;
    cell_cmd_t     cmd;
    entry_t        removed;

    entry_t        cell_entry [CAPACITY];
    entry_t        cell_tap   [CAPACITY];

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign pos_x  = XW'(s_data.position);
    assign fill_x = XW'(fill_count_reg);
    assign empty  = (fill_count_reg == '0);
    assign full   = (fill_count_reg >= CAP_C);

    // Decide the request against the current fill count.
    always_comb begin
        status  = ST_OK;
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        cmd.pos = POS_W'(s_data.position);
        unique case (s_data.kind)
            KIND_APPEND: begin
                cmd.pos = POS_W'(fill_count_reg);
                if (full) begin
                    status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            KIND_INSERT: begin
                if (pos_x > fill_x) begin
                    status = ST_BADPOS;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (pos_x >= fill_x) begin
                    status = ST_BADPOS;
                end else begin
                    do_rem = 1'b1;
                end
            end
            KIND_TAKE: begin
                cmd.pos = '0;
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    do_rem = 1'b1;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
        cmd.ins   = accept && do_ins;
        cmd.rem   = accept && do_rem;
        cmd.entry = '{key: s_data.entry_key, value: s_data.entry_value};
    end

    // Row of cells; each takes from its neighbours on a shift.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t left_e;
        entry_t right_e;
        if (i == 0) begin : g_head
            assign left_e = '0;
        end else begin : g_body_l
            assign left_e = cell_entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign right_e = '0;
        end else begin : g_body_r
            assign right_e = cell_entry[i+1];
        end
        pol_cell #(
            .INDEX (i)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .tap         (cell_tap[i])
        );
    end

    // Readout: at most one cell taps out, so OR the row.
    always_comb begin
        removed = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            removed = removed | cell_tap[i];
        end
    end

    always_comb begin
        fill_count_next = fill_count_reg;
        if (cmd.ins) begin
            fill_count_next = fill_count_reg + 1'b1;
        end else if (cmd.rem) begin
            fill_count_next = fill_count_reg - 1'b1;
        end

        out_next = out_reg;
        if (accept) begin
            out_next.status        = status;
            out_next.removed_valid = do_rem;
            out_next.removed_key   = do_rem ? removed.key   : '0;
            out_next.removed_value = do_rem ? removed.value : '0;
            out_next.count         = 5'(fill_count_next);
        end

        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            fill_count_reg <= fill_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Checks.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CAP_C)
        else $error("fill count above capacity");

    a_shift_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.ins && cmd.rem))
        else $error("insert and remove together");

    a_rem_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rem |=> fill_count_reg == CW'($past(fill_count_reg) - 1'b1))
        else $error("removal did not drop the count");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> fill_count_reg == CW'($past(fill_count_reg) + 1'b1))
        else $error("insert did not raise the count");

    a_removed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.removed_valid |-> m_data.status == ST_OK)
        else $error("removed entry on a rejected request");

endmodule

// ----- rtl/pol_cell.sv -----
module pol_cell
    import pol_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  entry_t    left_entry,
    input  entry_t    right_entry,
    output entry_t    entry,
    output entry_t    tap
);

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    entry_t entry_reg;
    entry_t entry_next;
    logic   at_pos;
    logic   past_pos;

    assign at_pos   = (cmd.pos == IDX);
    assign past_pos = (IDX > cmd.pos);

    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins) begin
            if (at_pos) begin
                entry_next = cmd.entry;
            end else if (past_pos) begin
                entry_next = left_entry;
            end
        end else if (cmd.rem && (at_pos || past_pos)) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    // Only the addressed cell drives its contents onto the readout tree.
    assign tap   = at_pos ? entry_reg : '0;

endmodule
